### rtl/tga_rle_pixel_decoder_core_macros.svh
// Assertion macros shared by the decoder modules.
`ifndef TGA_RLE_PIXEL_DECODER_CORE_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_CORE_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define TGARLE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define TGARLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tgarle_pkg.sv
// Shared types and constants of the TGA RLE pixel decoder.
package tgarle_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int COUNT_BITS_DEF      = 24;
	localparam int CFG_DATA_BITS       = 24;
	localparam int CFG_INDEX_BITS      = 2;

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEPTH_MODE  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RLE_ENABLE  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_COUNT = 2'd2;

	// Depth modes
	localparam logic [1:0] MODE_INDEXED = 2'd0;
	localparam logic [1:0] MODE_555     = 2'd1;
	localparam logic [1:0] MODE_BGR     = 2'd2;
	localparam logic [1:0] MODE_BGRA    = 2'd3;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0] RUN_HEADER_BIAS = 8'd127;

	// Palette write port
	typedef struct packed {
		logic        en;
		logic [7:0]  addr;
		logic [23:0] rgb;
	} pal_wr_t;

	// Palette read port
	typedef struct packed {
		logic       en;
		logic [7:0] addr;
	} pal_rd_t;

	// One decoded pixel before the palette colour is merged in
	typedef struct packed {
		logic       is_pal;
		logic       hit;
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		logic [7:0] a;
		logic [7:0] run;
		logic       last;
	} pix_t;

endpackage

### rtl/tgarle_palette.sv
// Palette memory: one write port, one registered read port.
module tgarle_palette #(
	parameter int PALETTE_ENTRIES = tgarle_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                clk,
	input  tgarle_pkg::pal_wr_t wr,
	input  tgarle_pkg::pal_rd_t rd,
	output logic [23:0]         rdata
);

	localparam int ENTRY_BITS = $clog2(PALETTE_ENTRIES);

	logic [23:0] mem [PALETTE_ENTRIES];
	logic [23:0] rdata_q;

	// Store a complete B,G,R entry
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[ENTRY_BITS-1:0]] <= wr.rgb;
		end
	end

	// Registered read; hold the data until the next read
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata_q <= mem[rd.addr[ENTRY_BITS-1:0]];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/tgarle_parser.sv
// Byte parser: configuration, palette load, packet headers and pixel gathering.
`include "tga_rle_pixel_decoder_core_macros.svh"

module tgarle_parser #(
	parameter int PALETTE_ENTRIES = tgarle_pkg::PALETTE_ENTRIES_DEF,
	parameter int COUNT_BITS      = tgarle_pkg::COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [tgarle_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [tgarle_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                 accept,
	input  logic [7:0]                           data_byte,
	output tgarle_pkg::pal_wr_t                  pal_wr,
	output tgarle_pkg::pal_rd_t                  pal_rd,
	output logic                                 emit,
	output tgarle_pkg::pix_t                     pix
);

	localparam int ENTRY_BITS = $clog2(PALETTE_ENTRIES);

	// Configuration registers
	logic [1:0]  depth_mode_q;
	logic        rle_enable_q;
	logic [23:0] pixel_count_q;
	logic [23:0] count_next;
	logic        cfg_hit;

	// Frame state
	logic                  pal_done_q;
	logic [ENTRY_BITS-1:0] pal_entry_q;
	logic [1:0]            pal_sub_q;
	logic [7:0]            pal_b_q;
	logic [7:0]            pal_g_q;
	logic [7:0]            pix_q [3];
	logic [1:0]            pos_q;
	logic [7:0]            rem_q;
	logic                  is_run_q;
	logic [COUNT_BITS-1:0] pixels_left_q;

	logic                  loading;
	logic                  header;
	logic                  complete;
	logic [COUNT_BITS-1:0] count_masked;
	logic [COUNT_BITS-1:0] load_val;
	logic [7:0]            hdr_len;
	logic [7:0]            hdr_clip;
	logic [7:0]            run_raw;
	logic [7:0]            run;
	logic [COUNT_BITS-1:0] left_after;
	logic                  last;
	logic [7:0]            p0, p1, p2;
	logic [15:0]           c16;

	// Pixel count as it stands after this cycle's write
	always_comb begin
		cfg_hit = cfg_write && (cfg_index == tgarle_pkg::REG_DEPTH_MODE ||
			cfg_index == tgarle_pkg::REG_RLE_ENABLE ||
			cfg_index == tgarle_pkg::REG_PIXEL_COUNT);
		count_next = (cfg_write && cfg_index == tgarle_pkg::REG_PIXEL_COUNT) ?
			cfg_data : pixel_count_q;
		count_masked = COUNT_BITS'(count_next);
		load_val = (count_masked == '0) ? COUNT_BITS'(1) : count_masked;
	end

	// Classify the byte and build the pixel
	always_comb begin
		loading  = (depth_mode_q == tgarle_pkg::MODE_INDEXED) && !pal_done_q;
		header   = !loading && rle_enable_q && (rem_q == 8'd0);
		complete = !loading && !header && (pos_q == depth_mode_q);

		hdr_len  = data_byte[7] ? (data_byte - tgarle_pkg::RUN_HEADER_BIAS) :
			(data_byte + 8'd1);
		hdr_clip = (COUNT_BITS'(hdr_len) > pixels_left_q) ? pixels_left_q[7:0] : hdr_len;

		run_raw  = (rle_enable_q && is_run_q) ? rem_q : 8'd1;
		run      = (COUNT_BITS'(run_raw) > pixels_left_q) ? pixels_left_q[7:0] : run_raw;
		left_after = pixels_left_q - COUNT_BITS'(run);
		last     = (left_after == '0);

		p0  = (depth_mode_q == tgarle_pkg::MODE_INDEXED) ? data_byte : pix_q[0];
		p1  = (depth_mode_q == tgarle_pkg::MODE_555) ? data_byte : pix_q[1];
		p2  = (depth_mode_q == tgarle_pkg::MODE_BGR) ? data_byte : pix_q[2];
		c16 = {p1, p0};

		pix = '0;
		pix.run  = run;
		pix.last = last;
		pix.a    = tgarle_pkg::ALPHA_OPAQUE;
		case (depth_mode_q)
			tgarle_pkg::MODE_INDEXED: begin
				pix.is_pal = 1'b1;
				pix.hit    = ({1'b0, data_byte} < 9'(PALETTE_ENTRIES));
			end
			tgarle_pkg::MODE_555: begin
				pix.b = {c16[4:0], 3'b000};
				pix.g = {c16[9:5], 3'b000};
				pix.r = {c16[14:10], 3'b000};
			end
			tgarle_pkg::MODE_BGR: begin
				pix.b = p0;
				pix.g = p1;
				pix.r = p2;
			end
			default: begin
				pix.b = p0;
				pix.g = p1;
				pix.r = p2;
				pix.a = data_byte;
			end
		endcase

		emit = accept && complete;

		pal_wr.en   = accept && loading && (pal_sub_q == 2'd2);
		pal_wr.addr = 8'(pal_entry_q);
		pal_wr.rgb  = {data_byte, pal_g_q, pal_b_q};

		pal_rd.en   = emit && pix.is_pal && pix.hit;
		pal_rd.addr = data_byte;
	end

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_mode_q  <= tgarle_pkg::MODE_BGRA;
			rle_enable_q  <= 1'b0;
			pixel_count_q <= 24'd1;
		end else if (cfg_write) begin
			case (cfg_index)
				tgarle_pkg::REG_DEPTH_MODE:  depth_mode_q  <= cfg_data[1:0];
				tgarle_pkg::REG_RLE_ENABLE:  rle_enable_q  <= cfg_data[0];
				tgarle_pkg::REG_PIXEL_COUNT: pixel_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the frame state; restart on frame end or a write to a configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_done_q    <= 1'b0;
			pal_entry_q   <= '0;
			pal_sub_q     <= 2'd0;
			pos_q         <= 2'd0;
			rem_q         <= 8'd0;
			is_run_q      <= 1'b0;
			pixels_left_q <= COUNT_BITS'(1);
		end else if (cfg_hit || (emit && last)) begin
			pal_done_q    <= 1'b0;
			pal_entry_q   <= '0;
			pal_sub_q     <= 2'd0;
			pos_q         <= 2'd0;
			rem_q         <= 8'd0;
			is_run_q      <= 1'b0;
			pixels_left_q <= load_val;
		end else if (accept) begin
			if (loading) begin
				if (pal_sub_q == 2'd2) begin
					pal_sub_q   <= 2'd0;
					pal_entry_q <= pal_entry_q + 1'b1;
					if (pal_entry_q == ENTRY_BITS'(PALETTE_ENTRIES - 1)) begin
						pal_done_q <= 1'b1;
					end
				end else begin
					pal_sub_q <= pal_sub_q + 2'd1;
				end
			end else if (header) begin
				is_run_q <= data_byte[7];
				rem_q    <= hdr_clip;
			end else if (!complete) begin
				pos_q <= pos_q + 2'd1;
			end else begin
				pos_q         <= 2'd0;
				pixels_left_q <= left_after;
				if (rle_enable_q) begin
					rem_q <= rem_q - run_raw;
				end
			end
		end
	end

	// Gather palette and pixel bytes
	always_ff @(posedge clk) begin
		if (accept && loading) begin
			if (pal_sub_q == 2'd0) begin
				pal_b_q <= data_byte;
			end
			if (pal_sub_q == 2'd1) begin
				pal_g_q <= data_byte;
			end
		end
		if (accept && !loading && !header && !complete && pos_q != 2'd3) begin
			pix_q[pos_q] <= data_byte;
		end
	end

	`TGARLE_ASSERT_ALWAYS(a_left_nonzero, pixels_left_q != '0, "pixels left reached zero")
	`TGARLE_ASSERT_ALWAYS(a_packet_clipped,
		COUNT_BITS'(rem_q) <= pixels_left_q, "packet runs past the frame")
	`TGARLE_ASSERT_NEXT(a_frame_reload, emit && last && !cfg_write,
		pixels_left_q == load_val && pos_q == 2'd0 && rem_q == 8'd0,
		"frame state not reloaded after the last pixel")

endmodule

### rtl/tgarle_out.sv
// Output pipeline: palette merge stage and output register with flow control.
`include "tga_rle_pixel_decoder_core_macros.svh"

module tgarle_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             emit,
	input  tgarle_pkg::pix_t pix,
	input  logic [23:0]      pal_rdata,
	output logic             busy,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_b,
	output logic [7:0]       out_g,
	output logic [7:0]       out_r,
	output logic [7:0]       out_a,
	output logic [7:0]       run_length,
	output logic             image_end
);

	logic             s1_valid_q;
	tgarle_pkg::pix_t pix_s1;
	logic             s2_valid_q;
	logic             s2_free;
	logic             s1_adv;
	logic [23:0]      colour;

	always_comb begin
		s2_free = !s2_valid_q || !out_stall;
		s1_adv  = s1_valid_q && s2_free;
		busy    = s1_valid_q && !s2_free;
		// Merge the palette colour; an index beyond the palette gives black
		if (pix_s1.is_pal) begin
			colour = pix_s1.hit ? pal_rdata : 24'd0;
		end else begin
			colour = {pix_s1.r, pix_s1.g, pix_s1.b};
		end
	end

	// Stage 1: hold the pixel while the palette read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!busy) begin
			s1_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy && emit) begin
			pix_s1 <= pix;
		end
	end

	// Stage 2: output register, held while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_free) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_b      <= colour[7:0];
			out_g      <= colour[15:8];
			out_r      <= colour[23:16];
			out_a      <= pix_s1.a;
			run_length <= pix_s1.run;
			image_end  <= pix_s1.last;
		end
	end

	assign out_valid = s2_valid_q;

	`TGARLE_ASSERT_ALWAYS(a_run_range,
		!out_valid || (run_length != 8'd0 && run_length <= 8'd128), "run length out of range")
	`TGARLE_ASSERT_NEXT(a_no_overwrite, busy && emit, 1'b0,
		"pixel emitted while the pipeline was full")
	`TGARLE_ASSERT_NEXT(a_s1_hold, busy, s1_valid_q && $stable(pix_s1),
		"stage 1 lost its pixel while blocked")

endmodule

### rtl/tga_rle_pixel_decoder_core.sv
// Top level of the TGA RLE pixel decoder.
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    data_byte
// output    out        out_valid / out_stall  out_b out_g out_r out_a run_length image_end
// config    in         cfg_write              cfg_index cfg_data
//
// One body byte is taken every cycle while in_stall is low; the state update and
// the palette read for a pixel finish in that cycle, and its result passes through
// the merge stage and then the output register. Indexed mode first spends 3*PALETTE_ENTRIES
// bytes loading the palette; the palette memory needs no clearing pass.
// Reset restores the register defaults and starts a frame. A stalled output
// holds its transaction while the merge stage still takes one more pixel.
module tga_rle_pixel_decoder_core #(
	parameter int PALETTE_ENTRIES = tgarle_pkg::PALETTE_ENTRIES_DEF,
	parameter int COUNT_BITS      = tgarle_pkg::COUNT_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [tgarle_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [tgarle_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [7:0]                            data_byte,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [7:0]                            out_b,
	output logic [7:0]                            out_g,
	output logic [7:0]                            out_r,
	output logic [7:0]                            out_a,
	output logic [7:0]                            run_length,
	output logic                                  image_end
);

	tgarle_pkg::pal_wr_t pal_wr;
	tgarle_pkg::pal_rd_t pal_rd;
	tgarle_pkg::pix_t    pix;
	logic [23:0]         pal_rdata;
	logic                emit;
	logic                busy;
	logic                accept;

	// Take a byte whenever the merge stage can move on
	assign in_stall = busy;
	assign accept   = in_valid && !busy;

	tgarle_parser #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES),
		.COUNT_BITS(COUNT_BITS)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.data_byte(data_byte),
		.pal_wr(pal_wr),
		.pal_rd(pal_rd),
		.emit(emit),
		.pix(pix)
	);

	tgarle_palette #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_palette (
		.clk(clk),
		.wr(pal_wr),
		.rd(pal_rd),
		.rdata(pal_rdata)
	);

	tgarle_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.emit(emit),
		.pix(pix),
		.pal_rdata(pal_rdata),
		.busy(busy),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_b(out_b),
		.out_g(out_g),
		.out_r(out_r),
		.out_a(out_a),
		.run_length(run_length),
		.image_end(image_end)
	);

endmodule
